// ===== design/uas_command_sequencer_macros.svh =====
// ----------------------------------------------------------------------------
// UAS command sequencer assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef UAS_COMMAND_SEQUENCER_MACROS_SVH
`define UAS_COMMAND_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UASCS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("uascs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define UASCS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("uascs assertion failed");

`endif

// ===== design/uascs_pkg.sv =====
// ----------------------------------------------------------------------------
// UAS command sequencer package
// Word types, command, action and status IU codes, and default limits.
// ----------------------------------------------------------------------------
package uascs_pkg;

    localparam int DEF_MAX_TRANSFER      = 4096;
    localparam int DEF_MAX_STATUS_ROUNDS = 3;

    localparam int CMD_W    = 2;
    localparam int ACTION_W = 3;
    localparam int TAG_W    = 16;
    localparam int XLEN_W   = 16;
    localparam int OLEN_W   = 13;
    localparam int ROUNDS_W = 2;
    localparam int RXB_W    = 7;

    // Input command codes.
    localparam logic [CMD_W-1:0] CMD_START     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STATUS_IU = 2'd1;
    localparam logic [CMD_W-1:0] CMD_XFER_FAIL = 2'd2;

    // Result action codes.
    localparam logic [ACTION_W-1:0] ACT_CMD_IU      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DATA_IN     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DATA_OUT    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_READ_STATUS = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SUCCESS     = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_FAILURE     = 3'd5;

    // Status IU identifiers.
    localparam logic [7:0] STS_SENSE       = 8'h03;
    localparam logic [7:0] STS_RESPONSE    = 8'h04;
    localparam logic [7:0] STS_READ_READY  = 8'h06;
    localparam logic [7:0] STS_WRITE_READY = 8'h07;

    localparam logic [RXB_W-1:0] IU_MIN_BYTES = 7'd4;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [XLEN_W-1:0] xfer_len;
        logic              to_device;
        logic [7:0]        iu_type;
        logic [TAG_W-1:0]  iu_tag;
        logic [7:0]        scsi_status;
        logic [RXB_W-1:0]  received_bytes;
    } in_word_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [TAG_W-1:0]    tag_out;
        logic [OLEN_W-1:0]   length_out;
        logic                last;
    } out_word_t;

endpackage

// ===== design/uas_command_sequencer.sv =====
// ----------------------------------------------------------------------------
// UAS command sequencer
// Host-side flow control for one tagged USB Attached SCSI command.
// ----------------------------------------------------------------------------
// Each event word is registered, decoded against the command state in one
// pass, and its zero, one or two result words are loaded into a two-entry
// output buffer. An accepted start or a ready IU with a length pending yields
// two results, which the single output port drains from the buffer one word
// per cycle while m_ready is high. The input register takes a word while results
// still wait, and the device_attached register is sampled only by start events.
`include "uas_command_sequencer_macros.svh"

module uas_command_sequencer
    import uascs_pkg::*;
#(
    parameter int MAX_TRANSFER      = DEF_MAX_TRANSFER,
    parameter int MAX_STATUS_ROUNDS = DEF_MAX_STATUS_ROUNDS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    // Pending length only needs to hold values up to the transfer limit.
    localparam int PEND_W = (MAX_TRANSFER >= 65535) ? XLEN_W : $clog2(MAX_TRANSFER + 1);

    logic                device_attached_reg;
    logic                in_valid_reg;
    in_word_t            in_reg;
    logic                busy_reg, busy_next;
    logic [TAG_W-1:0]    tag_counter_reg, tag_counter_next;
    logic [ROUNDS_W-1:0] rounds_used_reg, rounds_used_next;
    logic [PEND_W-1:0]   pending_length_reg, pending_length_next;
    out_word_t           res0_reg, res1_reg;
    logic [1:0]          out_cnt_reg;

    logic [ACTION_W-1:0] act0, act1;
    logic [OLEN_W-1:0]   len0;
    logic [1:0]          n_res;
    logic                advance;
    logic                pop;
    logic [TAG_W-1:0]    tag_inc;
    logic                next_fail;
    logic [XLEN_W-1:0]   pend_ext;

    assign pop     = m_valid && m_ready;
    assign advance = in_valid_reg && ((out_cnt_reg == 2'd0) || (out_cnt_reg == 2'd1 && m_ready));
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = (out_cnt_reg != 2'd0);
    assign m_data  = res0_reg;

    assign tag_inc   = tag_counter_reg + 1'b1;
    assign next_fail = 32'(rounds_used_reg + 1'b1) >= MAX_STATUS_ROUNDS;
    assign pend_ext  = XLEN_W'(pending_length_reg);

    always_comb begin
        busy_next           = busy_reg;
        tag_counter_next    = tag_counter_reg;
        rounds_used_next    = rounds_used_reg;
        pending_length_next = pending_length_reg;
        act0                = ACT_FAILURE;
        act1                = ACT_FAILURE;
        len0                = '0;
        n_res               = 2'd0;

        case (in_reg.cmd)
            CMD_START: begin
                n_res = 2'd1;
                if (!busy_reg && device_attached_reg &&
                    ({1'b0, in_reg.xfer_len} <= 17'(MAX_TRANSFER))) begin
                    tag_counter_next    = (tag_inc == '0) ? TAG_W'(1) : tag_inc;
                    busy_next           = 1'b1;
                    rounds_used_next    = '0;
                    pending_length_next = in_reg.xfer_len[PEND_W-1:0];
                    act0                = ACT_CMD_IU;
                    act1                = ACT_READ_STATUS;
                    n_res               = 2'd2;
                end
            end
            CMD_XFER_FAIL: begin
                if (busy_reg) begin
                    busy_next = 1'b0;
                    n_res     = 2'd1;
                end
            end
            CMD_STATUS_IU: begin
                if (busy_reg) begin
                    rounds_used_next = rounds_used_reg + 1'b1;
                    n_res            = 2'd1;
                    act0             = next_fail ? ACT_FAILURE : ACT_READ_STATUS;
                    busy_next        = !next_fail;
                    if (in_reg.received_bytes < IU_MIN_BYTES) begin
                        act0      = ACT_FAILURE;
                        busy_next = 1'b0;
                    end else if (in_reg.iu_tag == tag_counter_reg) begin
                        if (in_reg.iu_type == STS_SENSE) begin
                            act0      = (in_reg.scsi_status == 8'd0) ? ACT_SUCCESS : ACT_FAILURE;
                            busy_next = 1'b0;
                        end else if (in_reg.iu_type inside {STS_READ_READY, STS_WRITE_READY}) begin
                            // A zero-length ready IU just spends its round.
                            if (pending_length_reg != '0) begin
                                act0  = (in_reg.iu_type == STS_READ_READY) ?
                                        ACT_DATA_IN : ACT_DATA_OUT;
                                len0  = pend_ext[OLEN_W-1:0];
                                act1  = next_fail ? ACT_FAILURE : ACT_READ_STATUS;
                                n_res = 2'd2;
                            end
                        end else begin
                            // Response IUs and unknown types both end the command.
                            act0      = ACT_FAILURE;
                            busy_next = 1'b0;
                        end
                    end
                end
            end
            default: begin
                n_res = 2'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_attached_reg <= 1'b0;
        end else if (cfg_we) begin
            device_attached_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg           <= 1'b0;
            tag_counter_reg    <= '0;
            rounds_used_reg    <= '0;
            pending_length_reg <= '0;
        end else if (advance) begin
            busy_reg           <= busy_next;
            tag_counter_reg    <= tag_counter_next;
            rounds_used_reg    <= rounds_used_next;
            pending_length_reg <= pending_length_next;
        end
    end

    // The output buffer is reloaded only once it is empty or about to be.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_cnt_reg <= 2'd0;
        end else if (advance) begin
            out_cnt_reg <= n_res;
        end else if (pop) begin
            out_cnt_reg <= out_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res0_reg.action     <= act0;
            res0_reg.tag_out    <= tag_counter_next;
            res0_reg.length_out <= len0;
            res0_reg.last       <= (n_res == 2'd1);
            res1_reg.action     <= act1;
            res1_reg.tag_out    <= tag_counter_next;
            res1_reg.length_out <= '0;
            res1_reg.last       <= 1'b1;
        end else if (pop) begin
            res0_reg <= res1_reg;
        end
    end

    `UASCS_ASSERT_IMPL(a_nonlast_has_follower, aclk, aresetn, m_valid && !m_data.last, out_cnt_reg == 2'd2)
    `UASCS_ASSERT_IMPL(a_pair_ends_last, aclk, aresetn, out_cnt_reg == 2'd2, !res0_reg.last && res1_reg.last)
    `UASCS_ASSERT_IMPL(a_busy_tag_nonzero, aclk, aresetn, busy_reg, tag_counter_reg != '0)
    `UASCS_ASSERT_IMPL(a_busy_rounds_left, aclk, aresetn, busy_reg, 32'(rounds_used_reg) < MAX_STATUS_ROUNDS)
    `UASCS_ASSERT_NEXT(a_held_pair_stays, aclk, aresetn, out_cnt_reg == 2'd2 && !m_ready, out_cnt_reg == 2'd2)

endmodule

// ===== dv/uas_command_sequencer_test.sv =====
// ----------------------------------------------------------------------------
// UAS command sequencer testbench
// Drives event words into the sequencer and checks every result word against
// a cycle-free model of the command flow. A directed table covers the
// extremes and each error path, and random command sequences follow with
// random idling on both sides, one stretch without idling and one long
// output stall.
// ----------------------------------------------------------------------------
module uas_command_sequencer_test;
    import uascs_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int MAX_XFER        = DEF_MAX_TRANSFER;
    localparam int MAX_ROUNDS      = DEF_MAX_STATUS_ROUNDS;
    localparam int RANDOM_WORDS    = 1300;
    localparam int CFG_SPACING     = 225;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_CYCLES     = 300;
    localparam int IDLE_PCT        = 27;
    localparam int MAX_PRINTED     = 40;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t kind;
        in_word_t  w;
        logic      attach;
        int        n_typed;     // -1 when the model supplies the results
        out_word_t t0;
        out_word_t t1;
    } dir_row_t;

    logic      aclk;
    logic      aresetn;
    logic      cfg_we;
    logic      cfg_wdata;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    // Model state of the command flow.
    logic              attached;
    logic              cmd_busy;
    logic [TAG_W-1:0]  cur_tag;
    logic [ROUNDS_W-1:0] rounds;
    logic [OLEN_W-1:0] pend_len;

    out_word_t expected_words[$];
    dir_row_t  dir_rows[$];
    int        err_count;
    int        n_items;
    int        n_checked;
    int        n_wraps;
    bit        quiet;
    bit        hold_req;

    uas_command_sequencer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTED) begin
            $display("mismatch: %s", msg);
        end
    endtask

    function automatic in_word_t make_word(input logic [CMD_W-1:0] cmd,
                                           input logic [XLEN_W-1:0] xfer_len,
                                           input logic to_device,
                                           input logic [7:0] iu_type,
                                           input logic [TAG_W-1:0] iu_tag,
                                           input logic [7:0] scsi_status,
                                           input logic [RXB_W-1:0] rx_bytes);
        in_word_t w;
        w.cmd            = cmd;
        w.xfer_len       = xfer_len;
        w.to_device      = to_device;
        w.iu_type        = iu_type;
        w.iu_tag         = iu_tag;
        w.scsi_status    = scsi_status;
        w.received_bytes = rx_bytes;
        return w;
    endfunction

    function automatic out_word_t word_of(input logic [ACTION_W-1:0] act,
                                          input logic [OLEN_W-1:0] len,
                                          input logic lst);
        return out_word_t'{act, cur_tag, len, lst};
    endfunction

    // Advances the model by one event word; returns how many results it causes.
    function automatic int sequencer_step(input in_word_t w, output out_word_t r0,
                                          output out_word_t r1);
        logic [ACTION_W-1:0] follow;
        r0 = '0;
        r1 = '0;
        if (w.cmd == CMD_START) begin
            if (cmd_busy || !attached || w.xfer_len > MAX_XFER) begin
                r0 = word_of(ACT_FAILURE, '0, 1'b1);
                return 1;
            end
            if (cur_tag == 16'hFFFF) begin
                cur_tag = 16'd1;
                n_wraps++;
            end else begin
                cur_tag = cur_tag + 16'd1;
            end
            cmd_busy = 1'b1;
            rounds   = '0;
            pend_len = w.xfer_len[OLEN_W-1:0];
            r0 = word_of(ACT_CMD_IU, '0, 1'b0);
            r1 = word_of(ACT_READ_STATUS, '0, 1'b1);
            return 2;
        end
        if (w.cmd == CMD_XFER_FAIL) begin
            if (!cmd_busy) return 0;
            cmd_busy = 1'b0;
            r0 = word_of(ACT_FAILURE, '0, 1'b1);
            return 1;
        end
        if (w.cmd != CMD_STATUS_IU || !cmd_busy) return 0;

        rounds = rounds + 1'b1;
        follow = (rounds >= MAX_ROUNDS) ? ACT_FAILURE : ACT_READ_STATUS;
        if (w.received_bytes < IU_MIN_BYTES) begin
            cmd_busy = 1'b0;
            r0 = word_of(ACT_FAILURE, '0, 1'b1);
            return 1;
        end
        if (w.iu_tag == cur_tag) begin
            if (w.iu_type == STS_SENSE) begin
                cmd_busy = 1'b0;
                r0 = word_of((w.scsi_status == 8'd0) ? ACT_SUCCESS : ACT_FAILURE, '0, 1'b1);
                return 1;
            end
            if (w.iu_type == STS_READ_READY || w.iu_type == STS_WRITE_READY) begin
                // A zero-length ready IU falls through and just spends its round.
                if (pend_len != '0) begin
                    r0 = word_of((w.iu_type == STS_READ_READY) ? ACT_DATA_IN : ACT_DATA_OUT,
                                 pend_len, 1'b0);
                    if (follow == ACT_FAILURE) cmd_busy = 1'b0;
                    r1 = word_of(follow, '0, 1'b1);
                    return 2;
                end
            end else begin
                cmd_busy = 1'b0;
                r0 = word_of(ACT_FAILURE, '0, 1'b1);
                return 1;
            end
        end
        if (follow == ACT_FAILURE) cmd_busy = 1'b0;
        r0 = word_of(follow, '0, 1'b1);
        return 1;
    endfunction

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic send_word(input in_word_t w, input int n_typed,
                             input out_word_t t0, input out_word_t t1);
        out_word_t r0;
        out_word_t r1;
        int        n;
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_items++;
        n = sequencer_step(w, r0, r1);
        if (n_typed >= 0) begin
            n  = n_typed;
            r0 = t0;
            r1 = t1;
        end
        if (n > 0) expected_words.push_back(r0);
        if (n > 1) expected_words.push_back(r1);
    endtask

    task automatic send(input in_word_t w);
        send_word(w, -1, '0, '0);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_attach(input logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we   <= 1'b0;
        attached = v;
    endtask

    task automatic add_item(input in_word_t w, input int n,
                            input out_word_t t0, input out_word_t t1);
        dir_row_t r;
        r.kind    = ROW_ITEM;
        r.w       = w;
        r.attach  = 1'b0;
        r.n_typed = n;
        r.t0      = t0;
        r.t1      = t1;
        dir_rows.push_back(r);
    endtask

    task automatic add_cfg(input logic v);
        dir_row_t r;
        r.kind    = ROW_CFG;
        r.w       = '0;
        r.attach  = v;
        r.n_typed = 0;
        r.t0      = '0;
        r.t1      = '0;
        dir_rows.push_back(r);
    endtask

    task automatic add_status(input logic [7:0] iu_type, input logic [TAG_W-1:0] tag,
                              input logic [7:0] status, input logic [RXB_W-1:0] rx_bytes);
        add_item(make_word(CMD_STATUS_IU, '0, 1'b0, iu_type, tag, status, rx_bytes),
                 -1, '0, '0);
    endtask

    task automatic add_start(input logic [XLEN_W-1:0] len, input logic dir);
        add_item(make_word(CMD_START, len, dir, '0, '0, '0, '0), -1, '0, '0);
    endtask

    task automatic build_table();
        out_word_t fail0;
        fail0 = out_word_t'{ACT_FAILURE, 16'd0, 13'd0, 1'b1};
        add_cfg(1'b0);
        add_item(make_word(CMD_START, 16'd0, 1'b0, '0, '0, '0, '0), 1, fail0, '0);
        add_item(make_word(CMD_STATUS_IU, '0, 1'b0, STS_SENSE, 16'd0, '0, 7'd64), 0, '0, '0);
        add_item(make_word(CMD_XFER_FAIL, '0, 1'b0, '0, '0, '0, '0), 0, '0, '0);
        add_item(make_word(CMD_UNUSED, 16'hFFFF, 1'b1, 8'hFF, 16'hFFFF, 8'hFF, 7'h7F),
                 0, '0, '0);
        add_cfg(1'b1);
        add_item(make_word(CMD_START, 16'd4097, 1'b0, '0, '0, '0, '0), 1, fail0, '0);
        add_item(make_word(CMD_START, 16'hFFFF, 1'b1, '0, '0, '0, '0), 1, fail0, '0);
        add_item(make_word(CMD_START, 16'd4096, 1'b1, '0, '0, '0, '0), 2,
                 out_word_t'{ACT_CMD_IU, 16'd1, 13'd0, 1'b0},
                 out_word_t'{ACT_READ_STATUS, 16'd1, 13'd0, 1'b1});
        add_item(make_word(CMD_START, 16'd8, 1'b0, '0, '0, '0, '0), 1,
                 out_word_t'{ACT_FAILURE, 16'd1, 13'd0, 1'b1}, '0);
        add_status(STS_WRITE_READY, 16'd1, 8'd0, 7'd64);
        add_status(STS_SENSE, 16'd1, 8'd0, 7'd4);
        // Zero-length command: ready IUs only spend rounds until the budget runs out.
        add_start(16'd0, 1'b0);
        add_status(STS_READ_READY, 16'd2, 8'd0, 7'd127);
        add_status(STS_SENSE, 16'hFFFF, 8'd0, 7'd64);
        add_status(STS_READ_READY, 16'd2, 8'd0, 7'd64);
        add_start(16'd1, 1'b1);
        add_item(make_word(CMD_XFER_FAIL, '0, 1'b0, '0, '0, '0, '0), -1, '0, '0);
        add_start(16'd512, 1'b0);
        add_status(STS_SENSE, 16'd4, 8'd0, 7'd3);
        add_start(16'd4095, 1'b1);
        add_status(STS_RESPONSE, 16'd5, 8'd0, 7'd64);
        add_start(16'd100, 1'b0);
        add_status(8'hFF, 16'd6, 8'd0, 7'd64);
        // A data action in the last round is followed by failure.
        add_start(16'd4096, 1'b0);
        add_status(STS_READ_READY, 16'd7, 8'd0, 7'd64);
        add_status(STS_SENSE, 16'd0, 8'd0, 7'd64);
        add_status(STS_WRITE_READY, 16'd7, 8'd0, 7'd64);
        // Detaching does not stop a running command.
        add_start(16'd8, 1'b1);
        add_cfg(1'b0);
        add_status(STS_SENSE, 16'd8, 8'hFF, 7'd64);
        add_item(make_word(CMD_START, 16'd8, 1'b0, '0, '0, '0, '0), 1,
                 out_word_t'{ACT_FAILURE, 16'd8, 13'd0, 1'b1}, '0);
        add_cfg(1'b1);
    endtask

    function automatic logic [7:0] pick_iu_type();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30) return STS_READ_READY;
        if (roll < 55) return STS_WRITE_READY;
        if (roll < 80) return STS_SENSE;
        if (roll < 88) return STS_RESPONSE;
        return 8'($urandom_range(255));
    endfunction

    // One command: a start, then status IUs or an occasional transfer failure until it ends or six steps are sent.
    task automatic run_command();
        logic [XLEN_W-1:0] len;
        logic [TAG_W-1:0]  tag;
        int roll;
        int steps;
        roll = $urandom_range(99);
        if (roll < 15)      len = '0;
        else if (roll < 75) len = 16'($urandom_range(512, 1));
        else if (roll < 90) len = 16'($urandom_range(4096, 513));
        else if (roll < 95) len = 16'(MAX_XFER);
        else                len = 16'($urandom_range(65535, 4097));
        send(make_word(CMD_START, len, 1'($urandom_range(1)), 8'($urandom),
                       16'($urandom), 8'($urandom), 7'($urandom_range(127))));
        steps = 0;
        while (cmd_busy && steps < 6) begin
            if ($urandom_range(99) < 5) begin
                send(make_word(CMD_XFER_FAIL, 16'($urandom), 1'($urandom_range(1)),
                               8'($urandom), 16'($urandom), 8'($urandom),
                               7'($urandom_range(127))));
            end else begin
                tag = ($urandom_range(99) < 85) ? cur_tag : 16'($urandom);
                send(make_word(CMD_STATUS_IU, 16'($urandom), 1'($urandom_range(1)),
                               pick_iu_type(), tag,
                               ($urandom_range(99) < 60) ? 8'd0 : 8'($urandom),
                               ($urandom_range(99) < 90) ? 7'($urandom_range(64, 4))
                                                         : 7'($urandom_range(127))));
            end
            steps++;
        end
    endtask

    task automatic check_result(input out_word_t got);
        out_word_t want;
        if (expected_words.size() == 0) begin
            report_mismatch($sformatf("result with none expected: action %0d tag %h",
                                      got.action, got.tag_out));
            return;
        end
        want = expected_words.pop_front();
        n_checked++;
        if (got.action != want.action)
            report_mismatch($sformatf("action %0d, expected %0d", got.action, want.action));
        if (got.tag_out != want.tag_out)
            report_mismatch($sformatf("tag %h, expected %h", got.tag_out, want.tag_out));
        if (got.length_out != want.length_out)
            report_mismatch($sformatf("length %0d, expected %0d",
                                      got.length_out, want.length_out));
        if (got.last != want.last)
            report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
    endtask

    // Result side: random backpressure plus one long stall on request.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) check_result(m_data);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin : stimulus
        int rand_base;
        int next_cfg;
        int waited;
        bit pressed;
        attached  = 1'b0;
        cmd_busy  = 1'b0;
        cur_tag   = '0;
        rounds    = '0;
        pend_len  = '0;
        err_count = 0;
        n_items   = 0;
        n_checked = 0;
        n_wraps   = 0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        pressed   = 1'b0;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        build_table();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                wait_idle();
                write_attach(dir_rows[i].attach);
            end else begin
                send_word(dir_rows[i].w, dir_rows[i].n_typed, dir_rows[i].t0, dir_rows[i].t1);
            end
        end

        rand_base = n_items;
        next_cfg  = rand_base + CFG_SPACING;
        while (n_items - rand_base < RANDOM_WORDS) begin
            if (n_items >= next_cfg) begin
                wait_idle();
                write_attach($urandom_range(99) < 80);
                next_cfg += CFG_SPACING;
            end
            if (!pressed && n_items - rand_base >= 300) begin
                hold_req = 1'b1;
                pressed  = 1'b1;
            end
            quiet = (n_items - rand_base >= 700) && (n_items - rand_base < 850);
            if ($urandom_range(99) < 80) begin
                run_command();
            end else begin
                send(make_word(2'($urandom_range(3)), 16'($urandom), 1'($urandom_range(1)),
                               8'($urandom), 16'($urandom), 8'($urandom),
                               7'($urandom_range(127))));
            end
        end
        quiet = 1'b0;

        s_valid <= 1'b0;
        waited = 0;
        while (expected_words.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_words.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_words.size()));

        $display("summary: %0d event words sent, %0d results checked", n_items,
                 n_checked);
        $display("summary: tag counter wrapped %0d time(s), %0d mismatches", n_wraps,
                 err_count);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== uas_command_sequencer.f =====
+incdir+design
design/uascs_pkg.sv
design/uas_command_sequencer.sv
dv/uas_command_sequencer_test.sv
